// File: rtl/skd_pkg.sv
// skd_pkg: shared types, constants and codes of the sorted key directory.
// Used by skd_ctrl, skd_dp and sorted_key_directory_with_lru.
`default_nettype none
package skd_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [31:0] MIN_AGE_RESET = 32'd1000;

  localparam logic [2:0] MODE_ACCESS  = 3'd0;
  localparam logic [2:0] MODE_CREATE  = 3'd1;
  localparam logic [2:0] MODE_FREE    = 3'd2;
  localparam logic [2:0] MODE_BALANCE = 3'd3;
  localparam logic [2:0] MODE_FRAME   = 3'd4;

  typedef enum logic [3:0] {
    ST_HIT      = 4'd0,
    ST_INSERTED = 4'd1,
    ST_RELOADED = 4'd2,
    ST_MISMATCH = 4'd3,
    ST_CREATED  = 4'd4,
    ST_EXISTS   = 4'd5,
    ST_BAD_KIND = 4'd6,
    ST_FREED    = 4'd7,
    ST_ABSENT   = 4'd8,
    ST_EVICTED  = 4'd9,
    ST_MARKED   = 4'd10,
    ST_NONE     = 4'd11,
    ST_FULL     = 4'd12,
    ST_CLEARED  = 4'd13
  } code_t;

  typedef enum logic [1:0] {
    POS_ZERO,
    POS_LO,
    POS_SEL
  } pos_src_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LATCH,
    DP_SRCH_RD,
    DP_SRCH_UPD,
    DP_PROBE_RD,
    DP_PROBE_CAP,
    DP_UPDATE,
    DP_UP_INIT,
    DP_UP_RD,
    DP_UP_WR,
    DP_PUT,
    DP_DN_INIT_LO,
    DP_DN_INIT_SEL,
    DP_DN_RD,
    DP_DN_WR,
    DP_DN_END,
    DP_MARK_INIT,
    DP_MARK_RD,
    DP_MARK_WR,
    DP_SCAN_INIT,
    DP_SCAN_RD,
    DP_SCAN_CMP,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SRCH_CMP,
    S_PROBE_CAP,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_MARK_RD,
    S_MARK_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SEL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic        kind;
    logic        cach;
    logic        res;
    logic        mark;
    logic [31:0] last;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    dp_op_t   op;
    logic     reload;
    logic     set_res;
    code_t    code;
    pos_src_t pos_src;
    logic     lc_inc;
    logic     rc_inc;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       kind;
    logic       ok;
    logic       srch_done;
    logic       found;
    logic       full;
    logic       kind_match;
    logic       cach;
    logic       up_done;
    logic       dn_done;
    logic       mark_done;
    logic       scan_done;
    logic       any;
    logic       sel_res;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/sorted_key_directory_with_lru.sv
// Sorted key directory with LRU balance: top level joining sequencer and datapath.
// Depends on skd_pkg, skd_ctrl, skd_dp (and skd_ram below it).
//
// Usage:
//   Input channel in_valid/in_ready carries one word: mode, key, kind, now,
//   resource_ok. Output channel out_valid/out_ready returns one result word per
//   input word: status, position, key_out, loads_done, releases_done.
//   cfg_valid/cfg_ready writes min_idle_age (cfg_ready is always high); write
//   it only while the block is idle.
// Sequence (all entries in one single-port-read RAM):
//   every word runs a binary search, each step a RAM read and then a compare,
//   then a probe read, capture and decide, and ends with a hand-off to output.
//   Insert then shifts the entries from the slot on up by one, free and evict
//   shift the entries past the slot down by one, frame start clears the mark
//   of every entry, balance scans every entry and then may evict one. One word
//   is worked on at a time; each step is a RAM read, then a write or compare.
// Reset: synchronous, clears entry count, counters and min_idle_age to 1000;
//   no clearing pass, the table is usable on the next cycle.
// Stall: a finished result waits in the output register; the next word is
//   accepted and processed meanwhile, and holds in its last step until the
//   output register frees.
`default_nettype none
module sorted_key_directory_with_lru (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [31:0] key,
  input  wire logic        kind,
  input  wire logic [31:0] now,
  input  wire logic        resource_ok,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       status,
  output logic [7:0]       position,
  output logic [31:0]      key_out,
  output logic [31:0]      loads_done,
  output logic [31:0]      releases_done
);
  import skd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  skd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .key           (key),
    .kind          (kind),
    .now           (now),
    .resource_ok   (resource_ok),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .position      (position),
    .key_out       (key_out),
    .loads_done    (loads_done),
    .releases_done (releases_done)
  );

endmodule
`default_nettype wire

// File: rtl/skd_ram.sv
// skd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module skd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/skd_ctrl.sv
// skd_ctrl: sequencer of the directory; drives datapath commands from status.
// Depends on skd_pkg.
`default_nettype none
module skd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire skd_pkg::sts_t sts,
  output skd_pkg::cmd_t      cmd
);
  import skd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_SRCH;
      S_SRCH:      state_next = sts.srch_done ? S_PROBE_CAP : S_SRCH_CMP;
      S_SRCH_CMP:  state_next = S_SRCH;
      S_PROBE_CAP: state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = S_DONE;
        unique case (sts.mode)
          MODE_ACCESS:
            if (!sts.found && !sts.full) state_next = S_UP_RD;
          MODE_CREATE:
            if (sts.kind && !sts.found && !sts.full && sts.ok) state_next = S_UP_RD;
          MODE_FREE:
            if (sts.found) state_next = S_DN_RD;
          MODE_BALANCE: state_next = S_SCAN_RD;
          MODE_FRAME:   state_next = S_MARK_RD;
          default:      state_next = S_DONE;
        endcase
      end
      S_UP_RD:    state_next = sts.up_done ? S_DONE : S_UP_WR;
      S_UP_WR:    state_next = S_UP_RD;
      S_DN_RD:    state_next = sts.dn_done ? S_DONE : S_DN_WR;
      S_DN_WR:    state_next = S_DN_RD;
      S_MARK_RD:  state_next = sts.mark_done ? S_DONE : S_MARK_WR;
      S_MARK_WR:  state_next = S_MARK_RD;
      S_SCAN_RD:  state_next = sts.scan_done ? S_SEL : S_SCAN_CMP;
      S_SCAN_CMP: state_next = S_SCAN_RD;
      S_SEL:      state_next = (sts.any && !sts.sel_res) ? S_DN_RD : S_DONE;
      S_DONE:     if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.op = DP_NONE;
    cmd.code = ST_NONE;
    cmd.pos_src = POS_ZERO;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LATCH;
      end
      S_SRCH:      cmd.op = sts.srch_done ? DP_PROBE_RD : DP_SRCH_RD;
      S_SRCH_CMP:  cmd.op = DP_SRCH_UPD;
      S_PROBE_CAP: cmd.op = DP_PROBE_CAP;
      S_DECIDE: begin
        cmd.set_res = 1'b1;
        unique case (sts.mode)
          MODE_ACCESS: begin
            if (sts.found) begin
              cmd.pos_src = POS_LO;
              if (sts.kind_match) begin
                cmd.op = DP_UPDATE;
                cmd.code = ST_HIT;
              end else if (sts.cach && sts.ok) begin
                cmd.op = DP_UPDATE;
                cmd.reload = 1'b1;
                cmd.lc_inc = 1'b1;
                cmd.code = ST_RELOADED;
              end else begin
                cmd.code = ST_MISMATCH;
              end
            end else if (sts.full) begin
              cmd.code = ST_FULL;
            end else begin
              cmd.op = DP_UP_INIT;
              cmd.lc_inc = 1'b1;
              cmd.code = ST_INSERTED;
              cmd.pos_src = POS_LO;
            end
          end
          MODE_CREATE: begin
            if (!sts.kind) begin
              cmd.code = ST_BAD_KIND;
            end else if (sts.found) begin
              cmd.code = ST_EXISTS;
              cmd.pos_src = POS_LO;
            end else if (sts.full) begin
              cmd.code = ST_FULL;
            end else if (!sts.ok) begin
              cmd.code = ST_NONE;
            end else begin
              cmd.op = DP_UP_INIT;
              cmd.code = ST_CREATED;
              cmd.pos_src = POS_LO;
            end
          end
          MODE_FREE: begin
            if (sts.found) begin
              cmd.op = DP_DN_INIT_LO;
              cmd.code = ST_FREED;
              cmd.pos_src = POS_LO;
            end else begin
              cmd.code = ST_ABSENT;
            end
          end
          MODE_BALANCE: begin
            cmd.set_res = 1'b0;
            cmd.op = DP_SCAN_INIT;
          end
          MODE_FRAME: begin
            cmd.op = DP_MARK_INIT;
            cmd.code = ST_CLEARED;
          end
          default: cmd.code = ST_NONE;
        endcase
      end
      S_UP_RD:    cmd.op = sts.up_done ? DP_PUT : DP_UP_RD;
      S_UP_WR:    cmd.op = DP_UP_WR;
      S_DN_RD:    cmd.op = sts.dn_done ? DP_DN_END : DP_DN_RD;
      S_DN_WR:    cmd.op = DP_DN_WR;
      S_MARK_RD:  cmd.op = sts.mark_done ? DP_NONE : DP_MARK_RD;
      S_MARK_WR:  cmd.op = DP_MARK_WR;
      S_SCAN_RD:  cmd.op = sts.scan_done ? DP_NONE : DP_SCAN_RD;
      S_SCAN_CMP: cmd.op = DP_SCAN_CMP;
      S_SEL: begin
        cmd.set_res = 1'b1;
        if (sts.any) begin
          cmd.rc_inc = 1'b1;
          cmd.pos_src = POS_SEL;
          if (sts.sel_res) begin
            cmd.code = ST_MARKED;
          end else begin
            cmd.code = ST_EVICTED;
            cmd.op = DP_DN_INIT_SEL;
          end
        end else begin
          cmd.code = ST_NONE;
        end
      end
      S_DONE:  if (sts.out_free) cmd.op = DP_FINISH;
      default: cmd.op = DP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/skd_dp.sv
// skd_dp: entry memory, search and scan registers, counters and result word.
// Depends on skd_pkg and skd_ram.
`default_nettype none
module skd_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire skd_pkg::cmd_t cmd,
  output skd_pkg::sts_t      sts,
  input  wire logic [2:0]    mode,
  input  wire logic [31:0]   key,
  input  wire logic          kind,
  input  wire logic [31:0]   now,
  input  wire logic          resource_ok,
  input  wire logic          cfg_valid,
  input  wire logic [31:0]   cfg_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [3:0]         status,
  output logic [7:0]         position,
  output logic [31:0]        key_out,
  output logic [31:0]        loads_done,
  output logic [31:0]        releases_done
);
  import skd_pkg::*;

  logic [2:0]       op_mode;
  logic [31:0]      op_key;
  logic             op_kind;
  logic [31:0]      op_now;
  logic             op_ok;
  logic [CNT_W-1:0] lo, hi, ptr, count;
  logic [31:0]      load_cnt, rel_cnt, min_age, best;
  logic [IDX_W-1:0] sel, res_pos;
  logic             any, sel_res;
  code_t            res_code;
  entry_t           ent, rdata, wdata, upd, fresh;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid, ptr_dec, ptr_inc;
  logic [31:0]      age;
  logic             cand;
  logic [ENT_W-1:0] rdata_bits;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign ptr_dec = ptr - CNT_W'(1);
  assign ptr_inc = ptr + CNT_W'(1);
  assign rdata   = entry_t'(rdata_bits);
  assign age     = op_now - rdata.last;
  assign cand    = !(rdata.res && rdata.mark) && (age > best);

  always_comb begin
    upd = ent;
    upd.last = op_now;
    upd.mark = 1'b1;
    if (cmd.reload) begin
      upd.kind = op_kind;
      upd.res = 1'b1;
    end
    fresh.key = op_key;
    fresh.last = op_now;
    if (op_mode == MODE_CREATE) begin
      fresh.kind = 1'b1;
      fresh.cach = 1'b0;
      fresh.res = 1'b1;
      fresh.mark = 1'b0;
    end else begin
      fresh.kind = op_kind;
      fresh.cach = 1'b1;
      fresh.res = op_ok;
      fresh.mark = op_ok;
    end
  end

  always_comb begin
    re = 1'b0;
    raddr = ptr[IDX_W-1:0];
    we = 1'b0;
    waddr = ptr[IDX_W-1:0];
    wdata = rdata;
    case (cmd.op)
      DP_SRCH_RD:  begin re = 1'b1; raddr = mid[IDX_W-1:0]; end
      DP_PROBE_RD: begin re = 1'b1; raddr = lo[IDX_W-1:0]; end
      DP_UP_RD:    begin re = 1'b1; raddr = ptr_dec[IDX_W-1:0]; end
      DP_DN_RD:    begin re = 1'b1; raddr = ptr_inc[IDX_W-1:0]; end
      DP_MARK_RD:  re = 1'b1;
      DP_SCAN_RD:  begin re = 1'b1; raddr = ptr_dec[IDX_W-1:0]; end
      DP_UPDATE:   begin we = 1'b1; waddr = lo[IDX_W-1:0]; wdata = upd; end
      DP_UP_WR:    we = 1'b1;
      DP_DN_WR:    we = 1'b1;
      DP_PUT:      begin we = 1'b1; waddr = lo[IDX_W-1:0]; wdata = fresh; end
      DP_MARK_WR:  begin we = 1'b1; wdata.mark = 1'b0; end
      default:     we = 1'b0;
    endcase
  end

  skd_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      load_cnt <= '0;
      rel_cnt <= '0;
      min_age <= MIN_AGE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) min_age <= cfg_data;
      if (out_valid && out_ready && (cmd.op != DP_FINISH)) out_valid <= 1'b0;
      case (cmd.op)
        DP_LATCH: begin
          op_mode <= mode;
          op_key <= key;
          op_kind <= kind;
          op_now <= now;
          op_ok <= resource_ok;
          lo <= '0;
          hi <= count;
        end
        DP_SRCH_UPD: begin
          if (rdata.key < op_key) lo <= mid + CNT_W'(1);
          else hi <= mid;
        end
        DP_PROBE_CAP:   ent <= rdata;
        DP_UP_INIT:     ptr <= count;
        DP_UP_WR:       ptr <= ptr_dec;
        DP_PUT:         count <= count + CNT_W'(1);
        DP_DN_INIT_LO:  ptr <= lo;
        DP_DN_INIT_SEL: ptr <= CNT_W'(sel);
        DP_DN_WR:       ptr <= ptr_inc;
        DP_DN_END:      count <= count - CNT_W'(1);
        DP_MARK_INIT:   ptr <= '0;
        DP_MARK_WR:     ptr <= ptr_inc;
        DP_SCAN_INIT: begin
          ptr <= count;
          best <= min_age;
          any <= 1'b0;
        end
        DP_SCAN_CMP: begin
          if (cand) begin
            best <= age;
            sel <= ptr_dec[IDX_W-1:0];
            sel_res <= rdata.res;
            any <= 1'b1;
          end
          ptr <= ptr_dec;
        end
        DP_FINISH: begin
          out_valid <= 1'b1;
          status <= res_code;
          position <= 8'(res_pos);
          key_out <= (res_code == ST_CREATED) ? op_key : 32'd0;
          loads_done <= load_cnt;
          releases_done <= rel_cnt;
        end
        default: ;
      endcase
      if (cmd.lc_inc) load_cnt <= load_cnt + 32'd1;
      if (cmd.rc_inc) rel_cnt <= rel_cnt + 32'd1;
      if (cmd.set_res) begin
        res_code <= cmd.code;
        case (cmd.pos_src)
          POS_LO:  res_pos <= lo[IDX_W-1:0];
          POS_SEL: res_pos <= sel;
          default: res_pos <= '0;
        endcase
      end
    end
  end

  always_comb begin
    sts.mode = op_mode;
    sts.kind = op_kind;
    sts.ok = op_ok;
    sts.srch_done = (lo >= hi);
    sts.found = (lo < count) && (ent.key == op_key);
    sts.full = (count >= CNT_W'(CAPACITY));
    sts.kind_match = (ent.kind == op_kind);
    sts.cach = ent.cach;
    sts.up_done = (ptr <= lo);
    sts.dn_done = ({1'b0, ptr_inc} >= {1'b0, count}) || (ptr_inc == '0);
    sts.mark_done = (ptr >= count);
    sts.scan_done = (ptr == '0);
    sts.any = any;
    sts.sel_res = sel_res;
    sts.out_free = !out_valid || out_ready;
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_PUT) |-> (count < CNT_W'(CAPACITY)) && (lo <= count))
    else $error("insert into full table");

  a_up_shift: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_UP_WR) |-> (ptr > lo) && (ptr <= count))
    else $error("shift up out of range");

  a_load_step: assert property (@(posedge clk) disable iff (rst)
    (load_cnt != $past(load_cnt)) |-> (load_cnt == $past(load_cnt) + 32'd1))
    else $error("load counter jumped");

endmodule
`default_nettype wire

// File: sim/sorted_key_directory_with_lru_test.sv
// Self-checking testbench for sorted_key_directory_with_lru: random and directed words,
// a directory predictor checked per result word. Depends on skd_pkg and the RTL top.
`timescale 1ns / 1ps
module sorted_key_directory_with_lru_test;
  import skd_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd5;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] key;
    logic        kind;
    logic [31:0] now;
    logic        ok;
  } request_t;

  typedef struct {
    code_t       status;
    logic [7:0]  position;
    logic [31:0] key_out;
    logic [31:0] loads;
    logic [31:0] releases;
  } answer_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [2:0] mode = 0;
  logic [31:0] key = 0, now = 0;
  logic kind = 0, resource_ok = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [31:0] cfg_data = 0;
  logic out_valid, out_ready = 0;
  logic [3:0] status;
  logic [7:0] position;
  logic [31:0] key_out, loads_done, releases_done;

  sorted_key_directory_with_lru dut (.*);

  request_t pending_words[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int send_idle_pct = 15, recv_stall_pct = 84;
  int quiet_cycles = 0;

  // directory mirror
  entry_t      dir[CAPACITY];
  int          dir_count = 0;
  logic [31:0] dir_loads = 0, dir_releases = 0, dir_min_age = MIN_AGE_RESET;

  initial forever #5 clk = ~clk;

  function automatic int find_slot(logic [31:0] k);
    int lo = 0, hi = dir_count, mid;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (dir[mid].key < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void dir_insert(int at, entry_t e);
    for (int i = dir_count; i > at; i--) dir[i] = dir[i-1];
    dir[at] = e;
    dir_count++;
  endfunction

  function automatic void dir_erase(int at);
    for (int i = at; i + 1 < dir_count; i++) dir[i] = dir[i+1];
    dir_count--;
  endfunction

  function automatic answer_t directory_step(request_t r);
    answer_t a;
    int at, sel;
    logic found, any;
    logic [31:0] best, age;
    entry_t e;
    a.status = ST_NONE;
    a.position = 0;
    a.key_out = 0;
    at = find_slot(r.key);
    found = (at < dir_count) && (dir[at].key == r.key);
    case (r.mode)
      MODE_ACCESS: begin
        if (found) begin
          a.position = at[7:0];
          if (dir[at].kind == r.kind) begin
            dir[at].last = r.now;
            dir[at].mark = 1;
            a.status = ST_HIT;
          end else if (dir[at].cach && r.ok) begin
            dir_loads++;
            dir[at].kind = r.kind;
            dir[at].res = 1;
            dir[at].last = r.now;
            dir[at].mark = 1;
            a.status = ST_RELOADED;
          end else a.status = ST_MISMATCH;
        end else if (dir_count >= CAPACITY) a.status = ST_FULL;
        else begin
          dir_loads++;
          e = '{key: r.key, kind: r.kind, cach: 1, res: r.ok, mark: r.ok, last: r.now};
          dir_insert(at, e);
          a.position = at[7:0];
          a.status = ST_INSERTED;
        end
      end
      MODE_CREATE: begin
        if (r.kind != 1'b1) a.status = ST_BAD_KIND;
        else if (found) begin
          a.status = ST_EXISTS;
          a.position = at[7:0];
        end else if (dir_count >= CAPACITY) a.status = ST_FULL;
        else if (!r.ok) a.status = ST_NONE;
        else begin
          e = '{key: r.key, kind: 1, cach: 0, res: 1, mark: 0, last: r.now};
          dir_insert(at, e);
          a.position = at[7:0];
          a.key_out = r.key;
          a.status = ST_CREATED;
        end
      end
      MODE_FREE: begin
        if (found) begin
          dir_erase(at);
          a.position = at[7:0];
          a.status = ST_FREED;
        end else a.status = ST_ABSENT;
      end
      MODE_BALANCE: begin
        best = dir_min_age;
        any = 0;
        sel = 0;
        for (int j = dir_count - 1; j >= 0; j--) begin
          age = r.now - dir[j].last;
          if (!(dir[j].res && dir[j].mark) && age > best) begin
            best = age;
            sel = j;
            any = 1;
          end
        end
        if (any) begin
          dir_releases++;
          a.position = sel[7:0];
          if (dir[sel].res) a.status = ST_MARKED;
          else begin
            dir_erase(sel);
            a.status = ST_EVICTED;
          end
        end
      end
      MODE_FRAME: begin
        for (int i = 0; i < dir_count; i++) dir[i].mark = 0;
        a.status = ST_CLEARED;
      end
      default: ;
    endcase
    a.loads = dir_loads;
    a.releases = dir_releases;
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1;
          mode <= pending_words[0].mode;
          key <= pending_words[0].key;
          kind <= pending_words[0].kind;
          now <= pending_words[0].now;
          resource_ok <= pending_words[0].ok;
          pending_words.pop_front();
        end else in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t x;
    request_t r;
    bit moved;
    moved = 0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        moved = 1;
        if (expected_answers.size() == 0) begin
          $error("result word with nothing expected: status %0d", status);
          errors++;
        end else begin
          x = expected_answers.pop_front();
          if (status !== x.status) begin
            $error("status exp %0d got %0d", x.status, status); errors++;
          end
          if (position !== x.position) begin
            $error("position exp %0d got %0d", x.position, position); errors++;
          end
          if (key_out !== x.key_out) begin
            $error("key_out exp %h got %h", x.key_out, key_out); errors++;
          end
          if (loads_done !== x.loads) begin
            $error("loads_done exp %0d got %0d", x.loads, loads_done); errors++;
          end
          if (releases_done !== x.releases) begin
            $error("releases_done exp %0d got %0d", x.releases, releases_done); errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1;
        r = '{mode: mode, key: key, kind: kind, now: now, ok: resource_ok};
        expected_answers.push_back(directory_step(r));
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1;
        dir_min_age = cfg_data;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT && (pending_words.size() > 0 || in_valid ||
        expected_answers.size() > 0)) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  logic [31:0] key_pool[24];
  logic [31:0] tick = 0;

  function automatic void add(logic [2:0] m, logic [31:0] k, logic kd, logic [31:0] t,
                              logic ok);
    pending_words.push_back('{mode: m, key: k, kind: kd, now: t, ok: ok});
  endfunction

  function automatic void add_random(bit filling);
    logic [2:0] m;
    logic [31:0] k;
    int pick = $urandom_range(0, 99);
    tick += $urandom_range(0, 1500);
    if ($urandom_range(0, 49) == 0) tick = $urandom;
    if (filling) m = (pick < 80) ? MODE_ACCESS : (pick < 88) ? MODE_CREATE :
                     (pick < 94) ? MODE_FREE : MODE_BALANCE;
    else m = (pick < 40) ? MODE_ACCESS : (pick < 55) ? MODE_CREATE :
             (pick < 70) ? MODE_FREE : (pick < 85) ? MODE_BALANCE :
             (pick < 96) ? MODE_FRAME : 3'(MODE_UNUSED + $urandom_range(0, 2));
    k = (!filling && $urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 23)] : $urandom;
    add(m, k, 1'($urandom_range(0, 1)), tick, $urandom_range(0, 4) != 0);
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_min_age(logic [31:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 0;
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_min_age(32'd1000);

    // directed
    add(MODE_ACCESS, 32'h0, 0, 32'd10, 1);
    add(MODE_ACCESS, 32'hFFFF_FFFF, 1, 32'd20, 0);
    add(MODE_ACCESS, 32'h0, 0, 32'd30, 0);
    add(MODE_ACCESS, 32'h0, 1, 32'd40, 1);
    add(MODE_ACCESS, 32'h0, 0, 32'd50, 0);
    add(MODE_CREATE, 32'h5, 0, 32'd60, 1);
    add(MODE_CREATE, 32'h0, 1, 32'd70, 1);
    add(MODE_CREATE, 32'h5, 1, 32'd80, 0);
    add(MODE_CREATE, 32'h5, 1, 32'd90, 1);
    add(MODE_ACCESS, 32'h5, 0, 32'd95, 1);
    add(MODE_FREE, 32'h7, 0, 32'd100, 0);
    add(MODE_BALANCE, 32'h0, 0, 32'd500, 0);
    add(MODE_BALANCE, 32'h0, 0, 32'd5000, 0);
    add(MODE_FRAME, 32'h0, 0, 32'd5000, 0);
    add(MODE_BALANCE, 32'h0, 0, 32'hFFFF_FFFF, 1);
    add(MODE_BALANCE, 32'h0, 0, 32'hFFFF_FFFF, 1);
    add(MODE_FREE, 32'hFFFF_FFFF, 1, 32'd0, 1);
    add(MODE_UNUSED, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
    add(3'(MODE_UNUSED + 1), 32'h0, 0, 32'h0, 0);
    add(3'(MODE_UNUSED + 2), 32'h5, 1, 32'h1, 1);
    tick = 32'd6000;
    repeat (280) add_random(0);
    wait_idle();

    write_min_age(32'd0);
    send_idle_pct = 84;
    recv_stall_pct = 15;
    repeat (380) add_random(1);
    wait_idle();

    write_min_age(32'hFFFF_FFFF);
    repeat (80) add_random(0);
    wait_idle();

    write_min_age(32'd500);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (280) add_random(0);
    wait_idle();
    repeat (200) @(posedge clk);

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: sorted_key_directory_with_lru.f
rtl/skd_pkg.sv
rtl/skd_ram.sv
rtl/skd_ctrl.sv
rtl/skd_dp.sv
rtl/sorted_key_directory_with_lru.sv
sim/sorted_key_directory_with_lru_test.sv
